@@ sv/djv_pkg.sv @@
package djv_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 18;

    // input item kinds, carried on s_tuser
    localparam int KIND_WIDTH = 3;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_TICK    = 3'd0,
        KIND_MORE    = 3'd1,
        KIND_LESS    = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_INHIBIT = 3'd4
    } kind_t;

    // configuration register indexes
    localparam int ADDR_WIDTH = 3;

    localparam logic [ADDR_WIDTH-1:0] REG_DAMP_FACTOR   = 3'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_STEP_SIZE     = 3'd1;
    localparam logic [ADDR_WIDTH-1:0] REG_UPPER_LIMIT   = 3'd2;
    localparam logic [ADDR_WIDTH-1:0] REG_LOWER_LIMIT   = 3'd3;
    localparam logic [ADDR_WIDTH-1:0] REG_LINEAR_MODE   = 3'd4;
    localparam logic [ADDR_WIDTH-1:0] REG_MULTIPLY_MODE = 3'd5;

    // number of flag bits that follow the jog value in the result item
    localparam int FLAG_COUNT = 4;

    typedef struct packed {
        logic linear_mode;
        logic multiply_mode;
    } mode_t;

endpackage

@@ sv/djv_cfg.sv @@
module djv_cfg #(
    parameter int FRAC_BITS   = djv_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = djv_pkg::VALUE_WIDTH_DEF,
    parameter int CFG_WIDTH   = (FRAC_BITS + 1 > VALUE_WIDTH) ? FRAC_BITS + 1 : VALUE_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [djv_pkg::ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [CFG_WIDTH-1:0]              cfg_wdata,
    output logic [FRAC_BITS:0]                damp_factor,
    output logic [VALUE_WIDTH-2:0]            step_size,
    output logic signed [VALUE_WIDTH-1:0]     upper_limit,
    output logic signed [VALUE_WIDTH-1:0]     lower_limit,
    output djv_pkg::mode_t                    mode
);

    localparam logic [FRAC_BITS:0] DAMP_RST =
        (FRAC_BITS + 1)'((64'd95 << FRAC_BITS) / 64'd100);
    localparam logic [VALUE_WIDTH-2:0] STEP_RST =
        (VALUE_WIDTH - 1)'((64'd4 << FRAC_BITS) / 64'd1000);
    localparam logic [VALUE_WIDTH-1:0] UPPER_RST = VALUE_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [VALUE_WIDTH-1:0] LOWER_RST =
        VALUE_WIDTH'(64'd0 - (64'd1 << FRAC_BITS));

    logic [FRAC_BITS:0]       damp_reg;
    logic [VALUE_WIDTH-2:0]   step_reg;
    logic [VALUE_WIDTH-1:0]   upper_reg;
    logic [VALUE_WIDTH-1:0]   lower_reg;
    djv_pkg::mode_t           mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_reg               <= DAMP_RST;
            step_reg               <= STEP_RST;
            upper_reg              <= UPPER_RST;
            lower_reg              <= LOWER_RST;
            mode_reg.linear_mode   <= 1'b0;
            mode_reg.multiply_mode <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                djv_pkg::REG_DAMP_FACTOR:   damp_reg  <= cfg_wdata[FRAC_BITS:0];
                djv_pkg::REG_STEP_SIZE:     step_reg  <= cfg_wdata[VALUE_WIDTH-2:0];
                djv_pkg::REG_UPPER_LIMIT:   upper_reg <= cfg_wdata[VALUE_WIDTH-1:0];
                djv_pkg::REG_LOWER_LIMIT:   lower_reg <= cfg_wdata[VALUE_WIDTH-1:0];
                djv_pkg::REG_LINEAR_MODE:   mode_reg.linear_mode   <= cfg_wdata[0];
                djv_pkg::REG_MULTIPLY_MODE: mode_reg.multiply_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign damp_factor = damp_reg;
    assign step_size   = step_reg;
    assign upper_limit = $signed(upper_reg);
    assign lower_limit = $signed(lower_reg);
    assign mode        = mode_reg;

endmodule

@@ sv/djv_core.sv @@
module djv_core #(
    parameter int FRAC_BITS   = djv_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = djv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              item_take,
    input  logic [djv_pkg::KIND_WIDTH-1:0]    kind,
    input  logic                              level,
    input  logic [FRAC_BITS:0]                damp_factor,
    input  logic [VALUE_WIDTH-2:0]            step_size,
    input  logic signed [VALUE_WIDTH-1:0]     upper_limit,
    input  logic signed [VALUE_WIDTH-1:0]     lower_limit,
    input  djv_pkg::mode_t                    mode,
    output logic signed [VALUE_WIDTH-1:0]     value_out,
    output logic                              more_out,
    output logic                              less_out,
    output logic                              stop_out,
    output logic                              active_out
);

    localparam int VW = VALUE_WIDTH;
    localparam int DW = FRAC_BITS + 1;
    localparam int PW = VW + DW + 1;

    logic signed [VW-1:0] value_reg, value_next;
    logic signed [VW-1:0] delta_reg, delta_next;
    logic more_reg, more_next;
    logic less_reg, less_next;
    logic stop_reg, stop_next;
    logic active_reg, active_next;
    logic inhibit_reg, inhibit_next;

    logic signed [VW-1:0] step_s;
    logic signed [VW:0]   sum;
    logic signed [VW-1:0] clamped;
    logic signed [VW-1:0] v1;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic                 ovf;
    logic signed [VW-1:0] sat;
    logic signed [VW-1:0] damped;
    logic signed [VW:0]   vx, mdx, nmdx, lin_sub, lin_add;
    logic signed [VW-1:0] lin;
    logic signed [VW-1:0] tick_value;

    assign step_s = $signed({1'b0, step_size});

    // add the delta and clamp, upper limit tested first
    always_comb begin
        sum = {value_reg[VW-1], value_reg} + {delta_reg[VW-1], delta_reg};
        if (sum > $signed({upper_limit[VW-1], upper_limit})) begin
            clamped = upper_limit;
        end else if (sum < $signed({lower_limit[VW-1], lower_limit})) begin
            clamped = lower_limit;
        end else begin
            clamped = sum[VW-1:0];
        end
    end

    assign v1 = (active_reg && !inhibit_reg) ? clamped : value_reg;

    // floor of v1 * damp, saturated; an unchanged value snaps to zero
    assign prod    = $signed({{(DW + 1){v1[VW-1]}}, v1}) * $signed({{VW{1'b0}}, damp_factor});
    assign shifted = prod >>> FRAC_BITS;

    always_comb begin
        ovf = !((&shifted[PW-1:VW-1]) || !(|shifted[PW-1:VW-1]));
        if (ovf) begin
            sat = shifted[PW-1] ? $signed({1'b1, {(VW - 1){1'b0}}})
                                : $signed({1'b0, {(VW - 1){1'b1}}});
        end else begin
            sat = shifted[VW-1:0];
        end
        damped = (sat == v1) ? '0 : sat;
    end

    // constant step toward zero, multiply damping within one step of zero
    always_comb begin
        vx      = {v1[VW-1], v1};
        mdx     = {2'b00, step_size};
        nmdx    = -mdx;
        lin_sub = vx - mdx;
        lin_add = vx + mdx;
        if (vx > mdx) begin
            lin = (lin_sub < mdx) ? '0 : lin_sub[VW-1:0];
        end else if (vx < nmdx) begin
            lin = (lin_add > nmdx) ? '0 : lin_add[VW-1:0];
        end else begin
            lin = damped;
        end
    end

    always_comb begin
        if (mode.multiply_mode) begin
            tick_value = damped;
        end else if (mode.linear_mode && !active_reg) begin
            tick_value = lin;
        end else begin
            tick_value = v1;
        end
    end

    always_comb begin
        value_next   = value_reg;
        delta_next   = delta_reg;
        more_next    = more_reg;
        less_next    = less_reg;
        stop_next    = stop_reg;
        active_next  = active_reg;
        inhibit_next = inhibit_reg;
        case (djv_pkg::kind_t'(kind))
            djv_pkg::KIND_TICK: begin
                value_next = tick_value;
            end
            djv_pkg::KIND_MORE: begin
                more_next = level;
                if (level) begin
                    active_next = 1'b1;
                    delta_next  = step_s;
                end else if (less_reg) begin
                    delta_next = -step_s;
                end else begin
                    active_next = 1'b0;
                    delta_next  = '0;
                end
            end
            djv_pkg::KIND_LESS: begin
                less_next = level;
                if (level) begin
                    active_next = 1'b1;
                    delta_next  = -step_s;
                end else if (more_reg) begin
                    delta_next = step_s;
                end else begin
                    active_next = 1'b0;
                    delta_next  = '0;
                end
            end
            djv_pkg::KIND_STOP: begin
                stop_next = level;
                if (level) begin
                    // brake against the sign; leave delta alone at zero
                    if (value_reg > 0) begin
                        delta_next = -step_s;
                    end else if (value_reg < 0) begin
                        delta_next = step_s;
                    end
                end else begin
                    if (less_reg && !more_reg) begin
                        delta_next = -step_s;
                    end else if (!less_reg && more_reg) begin
                        delta_next = step_s;
                    end
                end
            end
            djv_pkg::KIND_INHIBIT: begin
                inhibit_next = level;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg   <= '0;
            delta_reg   <= '0;
            more_reg    <= 1'b0;
            less_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            active_reg  <= 1'b0;
            inhibit_reg <= 1'b0;
        end else if (item_take) begin
            value_reg   <= value_next;
            delta_reg   <= delta_next;
            more_reg    <= more_next;
            less_reg    <= less_next;
            stop_reg    <= stop_next;
            active_reg  <= active_next;
            inhibit_reg <= inhibit_next;
        end
    end

    assign value_out  = value_next;
    assign more_out   = more_next;
    assign less_out   = less_next;
    assign stop_out   = stop_next;
    assign active_out = active_next;

endmodule

@@ sv/djv_obuf.sv @@
module djv_obuf #(
    parameter int DATA_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  push_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata
);

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  skid_valid_reg;
    logic [DATA_WIDTH-1:0] skid_data_reg;
    logic                  pop;

    assign pop        = out_valid_reg && m_tready;
    assign push_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid stage first
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ sv/damped_jog_value_controller_core.sv @@
// A result item is registered into the output entry, or into the skid entry while
// the output entry holds a result not taken. Throughput: one item per cycle while
// s_tready is high; the state update (add, clamp, one multiply) is combinational.
// A two-entry output buffer absorbs m_tready stalls; s_tready drops only while
// both output entries hold untaken results. Reset: synchronous, active low aresetn;
// state and buffer clear, registers take their default values.
module damped_jog_value_controller_core #(
    parameter int FRAC_BITS   = djv_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = djv_pkg::VALUE_WIDTH_DEF,
    parameter int CFG_WIDTH   = (FRAC_BITS + 1 > VALUE_WIDTH) ? FRAC_BITS + 1 : VALUE_WIDTH,
    parameter int OUT_WIDTH   = ((VALUE_WIDTH + djv_pkg::FLAG_COUNT + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [0] level
    input  logic [djv_pkg::KIND_WIDTH-1:0]    s_tuser,  // [2:0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // jog value, more_held, less_held, stop_held, is_active, zero pad
    output logic [OUT_WIDTH-1:0]              m_tdata,
    input  logic                              cfg_we,
    input  logic [djv_pkg::ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [CFG_WIDTH-1:0]              cfg_wdata
);

    logic [FRAC_BITS:0]           damp_factor;
    logic [VALUE_WIDTH-2:0]       step_size;
    logic signed [VALUE_WIDTH-1:0] upper_limit;
    logic signed [VALUE_WIDTH-1:0] lower_limit;
    djv_pkg::mode_t               mode;
    logic                         item_take;
    logic signed [VALUE_WIDTH-1:0] value_out;
    logic                         more_out, less_out, stop_out, active_out;
    logic [OUT_WIDTH-1:0]         result;

    assign item_take = s_tvalid && s_tready;

    djv_cfg #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .damp_factor (damp_factor),
        .step_size   (step_size),
        .upper_limit (upper_limit),
        .lower_limit (lower_limit),
        .mode        (mode)
    );

    djv_core #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_take   (item_take),
        .kind        (s_tuser),
        .level       (s_tdata[0]),
        .damp_factor (damp_factor),
        .step_size   (step_size),
        .upper_limit (upper_limit),
        .lower_limit (lower_limit),
        .mode        (mode),
        .value_out   (value_out),
        .more_out    (more_out),
        .less_out    (less_out),
        .stop_out    (stop_out),
        .active_out  (active_out)
    );

    assign result = OUT_WIDTH'({active_out, stop_out, less_out, more_out, value_out});

    djv_obuf #(
        .DATA_WIDTH (OUT_WIDTH)
    ) u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (item_take),
        .push_data  (result),
        .push_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ sv/djv_checker.sv @@
module djv_checker #(
    parameter int OUT_WIDTH = 24
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_WIDTH-1:0] m_tdata
);

    // no result item right after a reset cycle
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item valid after reset");

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed or dropped");

    // a result item only follows an accepted input item
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result item without input item");

    // input is held off only while results are waiting
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind damped_jog_value_controller_core djv_checker #(
    .OUT_WIDTH (OUT_WIDTH)
) u_djv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
